// ----- design/melody_tone_sequencer_top_assert.svh -----
// ----------------------------------------------------------------------------
// melody tone sequencer assertion macros
// shared property forms for the checker of the melody tone sequencer
// ----------------------------------------------------------------------------
`ifndef MELODY_TONE_SEQUENCER_TOP_ASSERT_SVH
`define MELODY_TONE_SEQUENCER_TOP_ASSERT_SVH

// same-cycle implication
`define MTS_ASSERT_SAME(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("mts check failed");

// next-cycle implication
`define MTS_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("mts check failed");

`endif

// ----- design/mts_pkg.sv -----
// ----------------------------------------------------------------------------
// mts_pkg
// types, codes, reset values and song tables of the melody tone sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package mts_pkg;

  localparam int FUNC_W   = 2;
  localparam int TIME_W   = 32;
  localparam int CLK_W    = 32;
  localparam int GAP_W    = 16;
  localparam int WRAP_W   = 32;
  localparam int DUTY_W   = 31;
  localparam int NOTE_W   = 8;
  localparam int ROM_W    = 16;
  localparam int ROM_DEPTH = 80;
  localparam int ROM_AW   = 7;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam int SONG_LENGTH_DEF = 80;

  localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_STOP   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESUME = 2'd2;

  localparam logic REG_CLOCK_HZ = 1'b0;
  localparam logic REG_GAP_MS   = 1'b1;

  localparam logic [CLK_W-1:0] CLOCK_HZ_RST = 32'd125000000;
  localparam logic [GAP_W-1:0] GAP_MS_RST   = 16'd50;

  typedef logic [ROM_W-1:0] rom_word_t;

  localparam rom_word_t FREQ_TABLE [ROM_DEPTH] = '{
    16'd330, 16'd330, 16'd330, 16'd262, 16'd392, 16'd523, 16'd330, 16'd262,
    16'd392, 16'd523, 16'd330, 16'd659, 16'd659, 16'd659, 16'd698, 16'd523,
    16'd415, 16'd349, 16'd330, 16'd262, 16'd392, 16'd523, 16'd330, 16'd262,
    16'd392, 16'd523, 16'd330, 16'd659, 16'd659, 16'd659, 16'd698, 16'd523,
    16'd415, 16'd349, 16'd330, 16'd523, 16'd494, 16'd440, 16'd392, 16'd330,
    16'd659, 16'd784, 16'd659, 16'd523, 16'd494, 16'd440, 16'd392, 16'd330,
    16'd659, 16'd659, 16'd330, 16'd784, 16'd880, 16'd698, 16'd784, 16'd659,
    16'd523, 16'd494, 16'd440, 16'd392, 16'd659, 16'd784, 16'd659, 16'd523,
    16'd494, 16'd440, 16'd392, 16'd330, 16'd659, 16'd523, 16'd659, 16'd262,
    16'd330, 16'd294, 16'd247, 16'd262, 16'd220, 16'd262, 16'd330, 16'd262
  };

  localparam rom_word_t DUR_TABLE [ROM_DEPTH] = '{
    16'd500, 16'd500, 16'd500, 16'd350, 16'd150, 16'd300, 16'd500, 16'd350,
    16'd150, 16'd300, 16'd500, 16'd500, 16'd500, 16'd500, 16'd350, 16'd150,
    16'd300, 16'd500, 16'd500, 16'd350, 16'd150, 16'd300, 16'd500, 16'd350,
    16'd150, 16'd300, 16'd650, 16'd500, 16'd150, 16'd300, 16'd500, 16'd350,
    16'd150, 16'd300, 16'd500, 16'd150, 16'd300, 16'd500, 16'd350, 16'd150,
    16'd300, 16'd650, 16'd500, 16'd350, 16'd150, 16'd300, 16'd500, 16'd350,
    16'd150, 16'd300, 16'd500, 16'd500, 16'd500, 16'd500, 16'd350, 16'd150,
    16'd300, 16'd500, 16'd500, 16'd350, 16'd150, 16'd300, 16'd500, 16'd350,
    16'd150, 16'd300, 16'd500, 16'd350, 16'd150, 16'd300, 16'd500, 16'd500,
    16'd350, 16'd150, 16'd300, 16'd500, 16'd500, 16'd350, 16'd150, 16'd300
  };

  // entries past the table end read as a zero-length rest
  function automatic rom_word_t rom_freq(input logic [NOTE_W-1:0] idx);
    rom_word_t val;
    val = '0;
    if (32'(idx) < ROM_DEPTH) begin
      val = FREQ_TABLE[idx[ROM_AW-1:0]];
    end
    return val;
  endfunction

  function automatic rom_word_t rom_dur(input logic [NOTE_W-1:0] idx);
    rom_word_t val;
    val = '0;
    if (32'(idx) < ROM_DEPTH) begin
      val = DUR_TABLE[idx[ROM_AW-1:0]];
    end
    return val;
  endfunction

endpackage

`default_nettype wire

// ----- design/melody_tone_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// melody_tone_sequencer_top
// steps through a fixed song and reports buzzer pwm settings per transaction
// ----------------------------------------------------------------------------
// Each input transaction yields one result transaction. A stop, resume or
// plain timing update passes the fetch, evaluate and, in a gap, gap states
// before the result is written; an update that starts a sounding note also
// runs the restoring divider, forming clock_hz / frequency one quotient bit
// per cycle, before the wrap is decremented. in_ready is high only while
// the sequencer is idle; a finished result waits in the output register and
// does not block the next transaction from being accepted.
`default_nettype none

module melody_tone_sequencer_top
  import mts_pkg::*;
#(
  parameter int SONG_LENGTH = SONG_LENGTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [FUNC_W-1:0]  in_func,
  input  wire logic [TIME_W-1:0]  in_now_ms,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_pwm_on,
  output logic [WRAP_W-1:0]       out_wrap_value,
  output logic [DUTY_W-1:0]       out_duty_level,
  output logic                    out_tone_loaded,
  output logic [NOTE_W-1:0]       out_note_number,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_GAP   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_WRAP  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam logic [NOTE_W:0] SONG_LEN = (NOTE_W+1)'(SONG_LENGTH);
  localparam logic [4:0]      DIV_LAST = 5'd31;

  logic [2:0]        state_r, state_nxt;
  logic [FUNC_W-1:0] func_r, func_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [ROM_W-1:0]  freq_r, freq_nxt;
  logic [ROM_W-1:0]  dur_r, dur_nxt;
  logic [TIME_W-1:0] diff_r, diff_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [ROM_W-1:0]  rem_r, rem_nxt;
  logic [CLK_W-1:0]  quo_r, quo_nxt;

  logic [NOTE_W-1:0] note_pos_r, note_pos_nxt;
  logic [TIME_W-1:0] note_begin_r, note_begin_nxt;
  logic              playing_r, playing_nxt;
  logic              in_gap_r, in_gap_nxt;
  logic [TIME_W-1:0] gap_begin_r, gap_begin_nxt;
  logic              play_en_r, play_en_nxt;
  logic              pwm_run_r, pwm_run_nxt;
  logic [WRAP_W-1:0] wrap_r, wrap_nxt;
  logic              loaded_r, loaded_nxt;

  logic [CLK_W-1:0]  clock_hz_r, clock_hz_nxt;
  logic [GAP_W-1:0]  gap_ms_r, gap_ms_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_pwm_on_r, out_pwm_on_nxt;
  logic [WRAP_W-1:0] out_wrap_r, out_wrap_nxt;
  logic              out_loaded_r, out_loaded_nxt;
  logic [NOTE_W-1:0] out_note_r, out_note_nxt;

  logic              in_fire;
  logic              cfg_wr;
  logic [ROM_W:0]    trial;
  logic              trial_ge;
  logic [ROM_W:0]    trial_sub;
  logic [NOTE_W:0]   note_inc;
  logic [TIME_W-1:0] gap_diff;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;

  // divider step, one quotient bit per cycle
  assign trial     = {rem_r, quo_r[CLK_W-1]};
  assign trial_ge  = (trial >= {1'b0, freq_r});
  assign trial_sub = trial - {1'b0, freq_r};

  assign note_inc = {1'b0, note_pos_r} + (NOTE_W+1)'(1);
  assign gap_diff = now_r - gap_begin_r;

  always_comb begin
    case (paddr[2])
      REG_CLOCK_HZ: prdata = clock_hz_r;
      REG_GAP_MS:   prdata = {{(PDATA_W-GAP_W){1'b0}}, gap_ms_r};
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    clock_hz_nxt = clock_hz_r;
    gap_ms_nxt   = gap_ms_r;
    if (cfg_wr) begin
      case (paddr[2])
        REG_CLOCK_HZ: clock_hz_nxt = pwdata;
        REG_GAP_MS:   gap_ms_nxt   = pwdata[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    now_nxt        = now_r;
    freq_nxt       = freq_r;
    dur_nxt        = dur_r;
    diff_nxt       = diff_r;
    cnt_nxt        = cnt_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    note_pos_nxt   = note_pos_r;
    note_begin_nxt = note_begin_r;
    playing_nxt    = playing_r;
    in_gap_nxt     = in_gap_r;
    gap_begin_nxt  = gap_begin_r;
    play_en_nxt    = play_en_r;
    pwm_run_nxt    = pwm_run_r;
    wrap_nxt       = wrap_r;
    loaded_nxt     = loaded_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_pwm_on_nxt = out_pwm_on_r;
    out_wrap_nxt   = out_wrap_r;
    out_loaded_nxt = out_loaded_r;
    out_note_nxt   = out_note_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          func_nxt  = in_func;
          now_nxt   = in_now_ms;
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        freq_nxt   = rom_freq(note_pos_r);
        dur_nxt    = rom_dur(note_pos_r);
        diff_nxt   = now_r - note_begin_r;
        loaded_nxt = 1'b0;
        state_nxt  = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = S_DONE;
        case (func_r)
          FUNC_UPDATE: begin
            if (!play_en_r) begin
              pwm_run_nxt = 1'b0;
            end else if (!playing_r) begin
              note_begin_nxt = now_r;
              playing_nxt    = 1'b1;
              if (freq_r != '0) begin
                cnt_nxt   = '0;
                rem_nxt   = '0;
                quo_nxt   = clock_hz_r;
                state_nxt = S_DIV;
              end else begin
                pwm_run_nxt = 1'b0;
              end
            end else if (diff_r >= {{(TIME_W-ROM_W){1'b0}}, dur_r}) begin
              pwm_run_nxt = 1'b0;
              if (!in_gap_r) begin
                gap_begin_nxt = now_r;
                in_gap_nxt    = 1'b1;
              end else begin
                state_nxt = S_GAP;
              end
            end
          end
          FUNC_STOP:   play_en_nxt = 1'b0;
          FUNC_RESUME: play_en_nxt = 1'b1;
          default: ;
        endcase
      end
      S_GAP: begin
        if (gap_diff >= {{(TIME_W-GAP_W){1'b0}}, gap_ms_r}) begin
          note_pos_nxt = (note_inc >= SONG_LEN) ? '0 : note_inc[NOTE_W-1:0];
          playing_nxt  = 1'b0;
          in_gap_nxt   = 1'b0;
        end
        state_nxt = S_DONE;
      end
      S_DIV: begin
        rem_nxt = trial_ge ? trial_sub[ROM_W-1:0] : trial[ROM_W-1:0];
        quo_nxt = {quo_r[CLK_W-2:0], trial_ge};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_WRAP;
        end
      end
      S_WRAP: begin
        wrap_nxt    = quo_r - CLK_W'(1);
        pwm_run_nxt = 1'b1;
        loaded_nxt  = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_pwm_on_nxt = pwm_run_r;
          out_wrap_nxt   = wrap_r;
          out_loaded_nxt = loaded_r;
          out_note_nxt   = note_pos_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      note_pos_r   <= '0;
      note_begin_r <= '0;
      playing_r    <= 1'b0;
      in_gap_r     <= 1'b0;
      gap_begin_r  <= '0;
      play_en_r    <= 1'b1;
      pwm_run_r    <= 1'b0;
      wrap_r       <= '0;
      loaded_r     <= 1'b0;
      clock_hz_r   <= CLOCK_HZ_RST;
      gap_ms_r     <= GAP_MS_RST;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      note_pos_r   <= note_pos_nxt;
      note_begin_r <= note_begin_nxt;
      playing_r    <= playing_nxt;
      in_gap_r     <= in_gap_nxt;
      gap_begin_r  <= gap_begin_nxt;
      play_en_r    <= play_en_nxt;
      pwm_run_r    <= pwm_run_nxt;
      wrap_r       <= wrap_nxt;
      loaded_r     <= loaded_nxt;
      clock_hz_r   <= clock_hz_nxt;
      gap_ms_r     <= gap_ms_nxt;
      out_valid_r  <= out_valid_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    now_r        <= now_nxt;
    freq_r       <= freq_nxt;
    dur_r        <= dur_nxt;
    diff_r       <= diff_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    out_pwm_on_r <= out_pwm_on_nxt;
    out_wrap_r   <= out_wrap_nxt;
    out_loaded_r <= out_loaded_nxt;
    out_note_r   <= out_note_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pwm_on      = out_pwm_on_r;
  assign out_wrap_value  = out_wrap_r;
  assign out_duty_level  = out_wrap_r[WRAP_W-1:1];
  assign out_tone_loaded = out_loaded_r;
  assign out_note_number = out_note_r;

endmodule

`default_nettype wire

// ----- design/mts_checker.sv -----
// ----------------------------------------------------------------------------
// mts_checker
// port-level checks of the melody tone sequencer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "melody_tone_sequencer_top_assert.svh"

module mts_checker
  import mts_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              out_pwm_on,
  input wire logic [WRAP_W-1:0] out_wrap_value,
  input wire logic [DUTY_W-1:0] out_duty_level,
  input wire logic              out_tone_loaded
);

  `MTS_ASSERT_SAME(a_duty_half, out_valid, out_duty_level == out_wrap_value[WRAP_W-1:1])

  `MTS_ASSERT_SAME(a_loaded_sounds, out_valid && out_tone_loaded, out_pwm_on)

  // one transaction in flight at a time
  `MTS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  `MTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_wrap_value))

endmodule

bind melody_tone_sequencer_top mts_checker u_mts_checker (.*);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// melody tone sequencer testbench
// drives update, stop and resume transactions with a running millisecond
// clock aimed at note and gap boundaries, predicts every pwm result, and
// compares each result field by field across several clock and gap settings
// ----------------------------------------------------------------------------
module testbench;
  import mts_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [PADDR_W-1:0] ADDR_CLOCK_HZ = PADDR_W'(REG_CLOCK_HZ) << 2;
  localparam logic [PADDR_W-1:0] ADDR_GAP_MS = PADDR_W'(REG_GAP_MS) << 2;
  localparam int HOLD_CYCLES = 200;

  typedef struct packed {
    logic              pwm_on;
    logic [WRAP_W-1:0] wrap_value;
    logic [DUTY_W-1:0] duty_level;
    logic              tone_loaded;
    logic [NOTE_W-1:0] note_number;
  } tone_result_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TIME_W-1:0] now_ms;
    logic              typed;
    tone_result_t      tone;
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [FUNC_W-1:0]  in_func;
  logic [TIME_W-1:0]  in_now_ms;
  logic               out_valid;
  logic               out_ready;
  logic               out_pwm_on;
  logic [WRAP_W-1:0]  out_wrap_value;
  logic [DUTY_W-1:0]  out_duty_level;
  logic               out_tone_loaded;
  logic [NOTE_W-1:0]  out_note_number;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // predicted sequencer state and settings
  logic [CLK_W-1:0]   tune_clock_hz;
  logic [GAP_W-1:0]   tune_gap_ms;
  logic [NOTE_W-1:0]  seq_note;
  logic [TIME_W-1:0]  seq_note_start;
  logic               seq_sounding;
  logic               seq_resting;
  logic [TIME_W-1:0]  seq_gap_start;
  logic               seq_enabled;
  logic               seq_pwm;
  logic [WRAP_W-1:0]  seq_wrap;

  tone_result_t       expected_tones[$];
  tone_result_t       got_tone;
  tone_result_t       want_tone;
  logic [TIME_W-1:0]  cursor;
  int                 mismatches;
  bit                 idle_mode;
  bit                 quiet_tail;
  bit                 hold_output;
  stim_row_t          directed_rows [21];

  melody_tone_sequencer_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_now_ms       (in_now_ms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pwm_on      (out_pwm_on),
    .out_wrap_value  (out_wrap_value),
    .out_duty_level  (out_duty_level),
    .out_tone_loaded (out_tone_loaded),
    .out_note_number (out_note_number),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic logic [ROM_W-1:0] note_length(input logic [NOTE_W-1:0] idx);
    return (32'(idx) < ROM_DEPTH) ? DUR_TABLE[idx] : '0;
  endfunction

  function automatic tone_result_t sequence_step(input logic [FUNC_W-1:0] func,
                                                 input logic [TIME_W-1:0] now);
    tone_result_t res;
    logic [ROM_W-1:0] freq;
    logic loaded;
    loaded = 1'b0;
    freq = (32'(seq_note) < ROM_DEPTH) ? FREQ_TABLE[seq_note] : '0;
    case (func)
      FUNC_UPDATE: begin
        if (!seq_enabled) begin
          seq_pwm = 1'b0;
        end else if (!seq_sounding) begin
          seq_note_start = now;
          seq_sounding = 1'b1;
          if (freq != '0) begin
            seq_wrap = tune_clock_hz / 32'(freq) - 32'd1;
            seq_pwm = 1'b1;
            loaded = 1'b1;
          end else begin
            seq_pwm = 1'b0;
          end
        end else if ((now - seq_note_start) >= 32'(note_length(seq_note))) begin
          seq_pwm = 1'b0;
          if (!seq_resting) begin
            seq_gap_start = now;
            seq_resting = 1'b1;
          end else if ((now - seq_gap_start) >= 32'(tune_gap_ms)) begin
            if (32'(seq_note) + 32'd1 >= 32'(SONG_LENGTH_DEF)) begin
              seq_note = '0;
            end else begin
              seq_note = seq_note + 8'd1;
            end
            seq_sounding = 1'b0;
            seq_resting = 1'b0;
          end
        end
      end
      FUNC_STOP: seq_enabled = 1'b0;
      FUNC_RESUME: seq_enabled = 1'b1;
      default: ;
    endcase
    res.pwm_on = seq_pwm;
    res.wrap_value = seq_wrap;
    res.duty_level = seq_wrap[WRAP_W-1:1];
    res.tone_loaded = loaded;
    res.note_number = seq_note;
    return res;
  endfunction

  task automatic report_mismatch(input string text);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s", text);
    end
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic offer(input logic [FUNC_W-1:0] func, input logic [TIME_W-1:0] now,
                       input logic typed = 1'b0, input tone_result_t typed_tone = '0);
    tone_result_t pred;
    in_valid <= 1'b1;
    in_func <= func;
    in_now_ms <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = sequence_step(func, now);
    expected_tones.push_back(typed ? typed_tone : pred);
    @(negedge clk);
    if (idle_mode && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_tones.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic reg_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    data = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_tuning(input logic [CLK_W-1:0] clock_hz, input logic [GAP_W-1:0] gap);
    logic [PDATA_W-1:0] clock_back;
    logic [PDATA_W-1:0] gap_back;
    reg_write(ADDR_CLOCK_HZ, clock_hz);
    tune_clock_hz = clock_hz;
    reg_write(ADDR_GAP_MS, 32'(gap));
    tune_gap_ms = gap;
    reg_read(ADDR_CLOCK_HZ, clock_back);
    reg_read(ADDR_GAP_MS, gap_back);
    if (clock_back !== clock_hz || gap_back !== 32'(gap)) begin
      report_mismatch($sformatf("register readback: expected clock %0d gap %0d, got %0d %0d",
                                clock_hz, gap, clock_back, gap_back));
    end
  endtask

  // update times mostly land on or next to the current note or gap boundary
  task automatic play_phase(input int count);
    logic [TIME_W-1:0] mark;
    int pick;
    for (int i = 0; i < count; i++) begin
      if (i % 25 == 0) begin
        idle_mode = !quiet_tail && ($urandom_range(0, 2) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        offer(FUNC_STOP, $urandom);
      end else if (pick < 7 || (!seq_enabled && pick < 50)) begin
        offer(FUNC_RESUME, $urandom);
      end else if (pick < 9) begin
        offer(FUNC_UNUSED, $urandom);
      end else if (pick < 13) begin
        cursor = $urandom;
        offer(FUNC_UPDATE, cursor);
      end else begin
        if (seq_resting) begin
          mark = seq_gap_start + 32'(tune_gap_ms);
        end else if (seq_sounding) begin
          mark = seq_note_start + 32'(note_length(seq_note));
        end else begin
          mark = cursor;
        end
        case ($urandom_range(0, 3))
          0: cursor = mark - 32'd1;
          1: cursor = mark;
          2: cursor = mark + $urandom_range(1, 40);
          default: cursor = cursor + $urandom_range(0, 300);
        endcase
        offer(FUNC_UPDATE, cursor);
      end
    end
  endtask

  // result side
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_output) begin
        hold_output = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_ready <= 1'b1;
      end else if (idle_mode && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_tone.pwm_on = out_pwm_on;
      got_tone.wrap_value = out_wrap_value;
      got_tone.duty_level = out_duty_level;
      got_tone.tone_loaded = out_tone_loaded;
      got_tone.note_number = out_note_number;
      if (expected_tones.size() == 0) begin
        report_mismatch($sformatf("unexpected result transaction: note %0d wrap %h",
                                  got_tone.note_number, got_tone.wrap_value));
      end else begin
        want_tone = expected_tones.pop_front();
        if (got_tone.pwm_on !== want_tone.pwm_on
            || got_tone.wrap_value !== want_tone.wrap_value
            || got_tone.duty_level !== want_tone.duty_level
            || got_tone.tone_loaded !== want_tone.tone_loaded
            || got_tone.note_number !== want_tone.note_number) begin
          report_mismatch($sformatf(
            "tone mismatch: expected on %0b wrap %h duty %h load %0b note %0d, got on %0b wrap %h duty %h load %0b note %0d",
            want_tone.pwm_on, want_tone.wrap_value, want_tone.duty_level,
            want_tone.tone_loaded, want_tone.note_number,
            got_tone.pwm_on, got_tone.wrap_value, got_tone.duty_level,
            got_tone.tone_loaded, got_tone.note_number));
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FUNC_UPDATE;
    in_now_ms = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    idle_mode = 1'b1;
    quiet_tail = 1'b0;
    hold_output = 1'b0;
    tune_clock_hz = CLOCK_HZ_RST;
    tune_gap_ms = GAP_MS_RST;
    seq_note = '0;
    seq_note_start = '0;
    seq_sounding = 1'b0;
    seq_resting = 1'b0;
    seq_gap_start = '0;
    seq_enabled = 1'b1;
    seq_pwm = 1'b0;
    seq_wrap = '0;
    directed_rows = '{
      '{FUNC_UNUSED, 32'hFFFF_FFFF, 1'b1, '0},  // unused code ignored after reset
      '{FUNC_STOP,   32'h0000_0000, 1'b1, '0},
      '{FUNC_UPDATE, 32'd1000,      1'b1, '0},  // update while stopped
      '{FUNC_RESUME, 32'hFFFF_FFFF, 1'b1, '0},
      '{FUNC_UPDATE, 32'd0,         1'b0, '0},
      '{FUNC_UPDATE, 32'd499,       1'b0, '0},
      '{FUNC_UPDATE, 32'd500,       1'b0, '0},
      '{FUNC_UPDATE, 32'd549,       1'b0, '0},
      '{FUNC_UPDATE, 32'd550,       1'b0, '0},
      '{FUNC_UPDATE, 32'd551,       1'b0, '0},
      '{FUNC_STOP,   32'd0,         1'b0, '0},
      '{FUNC_UPDATE, 32'd5000,      1'b0, '0},
      '{FUNC_RESUME, 32'd0,         1'b0, '0},
      '{FUNC_UPDATE, 32'd5000,      1'b0, '0},  // note ends at once after long stop
      '{FUNC_UPDATE, 32'd5050,      1'b0, '0},
      '{FUNC_UPDATE, 32'hFFFF_FFF0, 1'b0, '0},  // note spans the time wrap
      '{FUNC_UPDATE, 32'h0000_01E3, 1'b0, '0},
      '{FUNC_UPDATE, 32'h0000_01E4, 1'b0, '0},
      '{FUNC_UPDATE, 32'h0000_0216, 1'b0, '0},
      '{FUNC_UPDATE, 32'h0000_0217, 1'b0, '0},
      '{FUNC_UNUSED, 32'h0000_0000, 1'b0, '0}
    };
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[k]) begin
      offer(directed_rows[k].func, directed_rows[k].now_ms,
            directed_rows[k].typed, directed_rows[k].tone);
    end
    cursor = 32'h0000_0217;
    play_phase(80);

    // clock below every note frequency, no gap
    drain();
    set_tuning(32'd1, 16'd0);
    play_phase(90);

    drain();
    set_tuning(32'hFFFF_FFFF, 16'hFFFF);
    play_phase(90);

    // clock between note frequencies, long output hold-off
    drain();
    set_tuning(32'd300, 16'($urandom_range(1, 200)));
    hold_output = 1'b1;
    play_phase(90);

    drain();
    quiet_tail = 1'b1;
    idle_mode = 1'b0;
    set_tuning($urandom_range(32'hFFFF_FFFF, 1), 16'($urandom_range(0, 2000)));
    play_phase(90);

    drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- melody_tone_sequencer_top.f -----
+incdir+design
design/mts_pkg.sv
design/melody_tone_sequencer_top.sv
design/mts_checker.sv
tb/sv/testbench.sv
